@@ rtl/core/ctrt_pkg.sv @@
// Shared types and constants of the cooperative task release table.
// Field widths, command/state/status codes, entry and result records.
// No dependencies.
package ctrt_pkg;

    localparam int POS_W         = 4;
    localparam int HANDLE_W      = 16;
    localparam int TIME_W        = 16;
    localparam int CMD_W         = 3;
    localparam int STATUS_W      = 2;
    localparam int COUNT_W       = 5;
    localparam int MAX_TASKS_DEF = 16;
    localparam int MAX_RESULTS   = 16;
    localparam int RES_CNT_W     = 5;
    localparam int S_TDATA_W     = 72;
    localparam int M_TDATA_W     = 48;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK     = 3'd0,
        CMD_CREATE   = 3'd1,
        CMD_SUSPEND  = 3'd2,
        CMD_RESUME   = 3'd3,
        CMD_DELETE   = 3'd4,
        CMD_DISPATCH = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        TS_DORMANT   = 2'd0,
        TS_READY     = 2'd1,
        TS_RELEASED  = 2'd2,
        TS_SUSPENDED = 2'd3
    } task_state_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK            = 2'd0,
        ST_FULL          = 2'd1,
        ST_NOT_OCCUPIED  = 2'd2,
        ST_NONE_RELEASED = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        SQ_IDLE,
        SQ_TICK_RD,
        SQ_TICK_WR,
        SQ_CREATE,
        SQ_RMW_RD,
        SQ_RMW_WR,
        SQ_SHIFT_RD,
        SQ_SHIFT_WR,
        SQ_DISP_RD,
        SQ_DISP_CHK,
        SQ_FINISH
    } seq_state_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] code;
        logic [HANDLE_W-1:0] param;
        logic [TIME_W-1:0]   countdown;
        logic [TIME_W-1:0]   period;
        task_state_t         state;
    } entry_t;

    typedef struct packed {
        cmd_t                cmd;
        logic [POS_W-1:0]    pos;
        logic [TIME_W-1:0]   release_time;
        logic [TIME_W-1:0]   period;
        logic [HANDLE_W-1:0] code;
        logic [HANDLE_W-1:0] param;
    } item_t;

    typedef struct packed {
        status_t             status;
        logic [POS_W-1:0]    position;
        logic [HANDLE_W-1:0] code;
        logic [HANDLE_W-1:0] param;
        logic [COUNT_W-1:0]  count;
    } result_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_req_t;

endpackage

@@ rtl/core/cooperative_task_release_table.sv @@
// Top level of the cooperative task release table: stream ports, packing,
// entry memory and command sequencer. Depends on ctrt_pkg, ctrt_mem, ctrt_seq.
//
// The table holds up to MAX_TASKS tasks in order, compacted at the front. One
// command item is taken when s_axis_tready is high; the block then stays busy
// until the last result of that item is in the output register, which holds
// it while the next item is already accepted. All table work goes through one
// memory port pair and one entry update unit, one entry per step. A tick reads
// and writes back each occupied entry, create writes one entry at the end,
// suspend and resume read and rewrite one entry, and delete moves every later
// entry down one place. A dispatch scans the entries in order; each one-shot
// task removed is compacted out the same way, and the removed position is then
// scanned again. While the output register stays full with m_axis_tready low,
// a result waits to move out. A dispatch returns one result per released task
// (at most 16), or a single no-release result if none is released, marked
// with m_axis_tlast on the final one.
module cooperative_task_release_table #(
    parameter int MAX_TASKS = ctrt_pkg::MAX_TASKS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // position[3:0], release_time[19:4], period[35:20], code_handle[51:36],
    // param_handle[67:52], zero fill[71:68]
    input  logic [ctrt_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // command[2:0]
    input  logic [ctrt_pkg::CMD_W-1:0]     s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // task_position[3:0], task_code[19:4], task_param[35:20],
    // task_count[40:36], zero fill[47:41]
    output logic [ctrt_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // status[1:0]
    output logic [ctrt_pkg::STATUS_W-1:0]  m_axis_tuser,
    output logic                           m_axis_tlast
);
    import ctrt_pkg::*;

    localparam int AW    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int M_PAD = M_TDATA_W - POS_W - 2 * HANDLE_W - COUNT_W;

    item_t    item;
    result_t  res;
    logic     res_last;
    mem_req_t mem_req;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    entry_t   wr_data;
    entry_t   rd_data;

    assign item.cmd          = cmd_t'(s_axis_tuser);
    assign item.pos          = s_axis_tdata[3:0];
    assign item.release_time = s_axis_tdata[19:4];
    assign item.period       = s_axis_tdata[35:20];
    assign item.code         = s_axis_tdata[51:36];
    assign item.param        = s_axis_tdata[67:52];

    assign m_axis_tdata = {{M_PAD{1'b0}}, res.count, res.param, res.code, res.position};
    assign m_axis_tuser = res.status;
    assign m_axis_tlast = res_last;

    ctrt_mem #(
        .DEPTH (MAX_TASKS),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .req     (mem_req),
        .rd_addr (rd_addr),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    ctrt_seq #(
        .MAX_TASKS (MAX_TASKS),
        .AW        (AW)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .item      (item),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .res       (res),
        .res_last  (res_last),
        .mem_req   (mem_req),
        .rd_addr   (rd_addr),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_data   (rd_data)
    );

`ifndef SYNTHESIS
    // an accepted item always leaves the sequencer busy in the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted on two consecutive cycles");

    // error and no-release results stand alone and carry no handles
    a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && res.status != ST_OK |->
            res.code == '0 && res.param == '0 && res_last)
        else $error("error result with handles or not final");

    // results ahead of the final one are dispatched tasks with a real code
    a_mid_is_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !res_last |-> res.status == ST_OK && res.code != '0)
        else $error("non-final result is not a dispatched task");
`endif

endmodule

@@ rtl/core/ctrt_upd.sv @@
// Tick update unit: next countdown and state of one table entry.
// Depends on ctrt_pkg.
module ctrt_upd (
    input  ctrt_pkg::entry_t cur,
    output ctrt_pkg::entry_t nxt
);
    import ctrt_pkg::*;

    always_comb
    begin
        nxt = cur;
        // an empty code handle never counts down
        if (cur.code != '0)
        begin
            if (cur.countdown == '0)
            begin
                if (cur.state != TS_SUSPENDED)
                begin
                    nxt.state = TS_RELEASED;
                end
                if (cur.period != '0)
                begin
                    nxt.countdown = cur.period;
                end
            end
            else
            begin
                nxt.countdown = cur.countdown - 1'b1;
            end
        end
    end

endmodule

@@ rtl/core/ctrt_mem.sv @@
// Task entry memory: one write port, one read port with registered data.
// Depends on ctrt_pkg.
module ctrt_mem #(
    parameter int DEPTH = ctrt_pkg::MAX_TASKS_DEF,
    parameter int AW    = 4
) (
    input  logic              clk,
    input  ctrt_pkg::mem_req_t req,
    input  logic [AW-1:0]     rd_addr,
    input  logic [AW-1:0]     wr_addr,
    input  ctrt_pkg::entry_t  wr_data,
    output ctrt_pkg::entry_t  rd_data
);
    import ctrt_pkg::*;

    entry_t mem_arr [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem_arr[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data_reg <= mem_arr[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/ctrt_seq.sv @@
// Command sequencer: walks the entry memory one entry at a time for tick,
// create, suspend/resume, delete (with compaction) and dispatch.
// Depends on ctrt_pkg and ctrt_upd.
module ctrt_seq #(
    parameter int MAX_TASKS = ctrt_pkg::MAX_TASKS_DEF,
    parameter int AW        = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ctrt_pkg::item_t    item,
    output logic               out_valid,
    input  logic               out_ready,
    output ctrt_pkg::result_t  res,
    output logic               res_last,
    output ctrt_pkg::mem_req_t mem_req,
    output logic [AW-1:0]      rd_addr,
    output logic [AW-1:0]      wr_addr,
    output ctrt_pkg::entry_t   wr_data,
    input  ctrt_pkg::entry_t   rd_data
);
    import ctrt_pkg::*;

    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    seq_state_t           state_reg, state_next;
    item_t                item_reg, item_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        idx_reg, idx_next;
    logic [CW-1:0]        sh_reg, sh_next;
    logic [RES_CNT_W-1:0] n_reg, n_next;
    result_t              pend_reg, pend_next;
    logic                 pend_valid_reg, pend_valid_next;
    result_t              out_reg, out_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_last_reg, out_last_next;

    entry_t               upd_nxt;
    logic                 out_free;
    logic [CW-1:0]        idx_inc;
    logic [CW-1:0]        sh_inc;
    logic [CW-1:0]        count_dec;
    logic [AW-1:0]        pos_addr;

    function automatic result_t make_res(
        input status_t             st,
        input logic [POS_W-1:0]    p,
        input logic [HANDLE_W-1:0] c,
        input logic [HANDLE_W-1:0] q,
        input logic [COUNT_W-1:0]  n
    );
        result_t r;
        r.status   = st;
        r.position = p;
        r.code     = c;
        r.param    = q;
        r.count    = n;
        return r;
    endfunction

    ctrt_upd u_upd (
        .cur (rd_data),
        .nxt (upd_nxt)
    );

    assign out_free  = !out_valid_reg || out_ready;
    assign idx_inc   = idx_reg + 1'b1;
    assign sh_inc    = sh_reg + 1'b1;
    assign count_dec = count_reg - 1'b1;
    assign pos_addr  = AW'(item_reg.pos);

    assign out_valid = out_valid_reg;
    assign res       = out_reg;
    assign res_last  = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= SQ_IDLE;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        idx_reg      <= idx_next;
        sh_reg       <= sh_next;
        n_reg        <= n_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        sh_next         = sh_reg;
        n_next          = n_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        out_last_next   = out_last_reg;
        in_ready        = 1'b0;
        mem_req.rd_en   = 1'b0;
        mem_req.wr_en   = 1'b0;
        rd_addr         = AW'(idx_reg);
        wr_addr         = AW'(idx_reg);
        wr_data         = rd_data;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            SQ_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    item_next       = item;
                    idx_next        = '0;
                    n_next          = '0;
                    pend_valid_next = 1'b0;
                    case (item.cmd)
                        CMD_TICK:
                        begin
                            if (count_reg == '0)
                            begin
                                pend_next  = make_res(ST_OK, '0, '0, '0,
                                                      COUNT_W'(count_reg));
                                state_next = SQ_FINISH;
                            end
                            else
                            begin
                                state_next = SQ_TICK_RD;
                            end
                        end
                        CMD_CREATE:
                        begin
                            if (count_reg >= CW'(MAX_TASKS))
                            begin
                                pend_next  = make_res(ST_FULL, '0, '0, '0,
                                                      COUNT_W'(count_reg));
                                state_next = SQ_FINISH;
                            end
                            else
                            begin
                                state_next = SQ_CREATE;
                            end
                        end
                        CMD_SUSPEND, CMD_RESUME, CMD_DELETE:
                        begin
                            if (PW'(item.pos) >= PW'(count_reg))
                            begin
                                pend_next  = make_res(ST_NOT_OCCUPIED, item.pos, '0, '0,
                                                      COUNT_W'(count_reg));
                                state_next = SQ_FINISH;
                            end
                            else if (item.cmd == CMD_DELETE)
                            begin
                                sh_next    = CW'(item.pos);
                                state_next = SQ_SHIFT_RD;
                            end
                            else
                            begin
                                state_next = SQ_RMW_RD;
                            end
                        end
                        CMD_DISPATCH:
                        begin
                            state_next = SQ_DISP_RD;
                        end
                        default:
                        begin
                            pend_next  = make_res(ST_OK, '0, '0, '0,
                                                  COUNT_W'(count_reg));
                            state_next = SQ_FINISH;
                        end
                    endcase
                end
            end

            SQ_TICK_RD:
            begin
                mem_req.rd_en = 1'b1;
                state_next    = SQ_TICK_WR;
            end

            SQ_TICK_WR:
            begin
                // write back this entry, fetch the next one in the same cycle
                mem_req.wr_en = 1'b1;
                wr_data       = upd_nxt;
                idx_next      = idx_inc;
                if (idx_inc == count_reg)
                begin
                    pend_next  = make_res(ST_OK, '0, '0, '0, COUNT_W'(count_reg));
                    state_next = SQ_FINISH;
                end
                else
                begin
                    mem_req.rd_en = 1'b1;
                    rd_addr       = AW'(idx_inc);
                end
            end

            SQ_CREATE:
            begin
                mem_req.wr_en     = 1'b1;
                wr_addr           = AW'(count_reg);
                wr_data.code      = item_reg.code;
                wr_data.param     = item_reg.param;
                wr_data.countdown = item_reg.release_time;
                wr_data.period    = item_reg.period;
                wr_data.state     = TS_DORMANT;
                count_next        = count_reg + 1'b1;
                pend_next         = make_res(ST_OK, POS_W'(count_reg), '0, '0,
                                             COUNT_W'(count_reg + 1'b1));
                state_next        = SQ_FINISH;
            end

            SQ_RMW_RD:
            begin
                mem_req.rd_en = 1'b1;
                rd_addr       = pos_addr;
                state_next    = SQ_RMW_WR;
            end

            SQ_RMW_WR:
            begin
                mem_req.wr_en = 1'b1;
                wr_addr       = pos_addr;
                wr_data.state = (item_reg.cmd == CMD_SUSPEND) ? TS_SUSPENDED : TS_READY;
                pend_next     = make_res(ST_OK, item_reg.pos, '0, '0,
                                         COUNT_W'(count_reg));
                state_next    = SQ_FINISH;
            end

            SQ_SHIFT_RD:
            begin
                if (sh_inc < count_reg)
                begin
                    mem_req.rd_en = 1'b1;
                    rd_addr       = AW'(sh_inc);
                    state_next    = SQ_SHIFT_WR;
                end
                else
                begin
                    count_next = count_dec;
                    if (item_reg.cmd == CMD_DELETE)
                    begin
                        pend_next  = make_res(ST_OK, item_reg.pos, '0, '0,
                                              COUNT_W'(count_dec));
                        state_next = SQ_FINISH;
                    end
                    else
                    begin
                        // resume the dispatch scan at the same position
                        state_next = SQ_DISP_RD;
                    end
                end
            end

            SQ_SHIFT_WR:
            begin
                mem_req.wr_en = 1'b1;
                wr_addr       = AW'(sh_reg);
                sh_next       = sh_inc;
                state_next    = SQ_SHIFT_RD;
            end

            SQ_DISP_RD:
            begin
                if (idx_reg >= count_reg || n_reg == RES_CNT_W'(MAX_RESULTS))
                begin
                    if (!pend_valid_reg)
                    begin
                        pend_next = make_res(ST_NONE_RELEASED, '0, '0, '0,
                                             COUNT_W'(count_reg));
                    end
                    state_next = SQ_FINISH;
                end
                else
                begin
                    mem_req.rd_en = 1'b1;
                    state_next    = SQ_DISP_CHK;
                end
            end

            SQ_DISP_CHK:
            begin
                if (rd_data.state == TS_RELEASED)
                begin
                    // hold until the previous result can move to the output
                    if (!pend_valid_reg || out_free)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_next       = pend_reg;
                            out_valid_next = 1'b1;
                            out_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        n_next          = n_reg + 1'b1;
                        if (rd_data.period == '0)
                        begin
                            pend_next  = make_res(ST_OK, POS_W'(idx_reg), rd_data.code,
                                                  rd_data.param, COUNT_W'(count_dec));
                            sh_next    = idx_reg;
                            state_next = SQ_SHIFT_RD;
                        end
                        else
                        begin
                            pend_next     = make_res(ST_OK, POS_W'(idx_reg), rd_data.code,
                                                     rd_data.param, COUNT_W'(count_reg));
                            mem_req.wr_en = 1'b1;
                            wr_data.state = TS_READY;
                            idx_next      = idx_inc;
                            state_next    = SQ_DISP_RD;
                        end
                    end
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = SQ_DISP_RD;
                end
            end

            SQ_FINISH:
            begin
                if (out_free)
                begin
                    out_next        = pend_reg;
                    out_valid_next  = 1'b1;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = SQ_IDLE;
                end
            end

            default:
            begin
                state_next = SQ_IDLE;
            end
        endcase
    end

endmodule
